// ----- hdl/cac_pkg.sv -----
// Shared types and constants for the cursor autorepeat controller.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cac_pkg;

   // Board and word geometry
   localparam int MAX_SIDE  = 16;            // largest board side honored by the clamp
   localparam int CURSOR_W  = 4;             // cursor coordinate width
   localparam int CALC_W    = CURSOR_W + 2;  // signed room for up to two steps past either edge
   localparam int SIDE_W    = 5;             // board size field width
   localparam int TIME_W    = 16;            // time and countdown width
   localparam int STEP_W    = 3;             // step count width
   localparam int NUM_DIRS  = 4;

   // Direction codes, in processing order
   typedef enum logic [1:0] {
      MOVE_UP    = 2'd0,
      MOVE_LEFT  = 2'd1,
      MOVE_DOWN  = 2'd2,
      MOVE_RIGHT = 2'd3
   } dir_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_INITIAL_DELAY   = 1'b0,
      CSR_REPEAT_INTERVAL = 1'b1
   } csr_index_type;

   // Input word: one frame
   typedef struct packed {
      logic              held_up;
      logic              held_left;
      logic              held_down;
      logic              held_right;
      logic [TIME_W-1:0] elapsed_time;
      logic [SIDE_W-1:0] board_width;
      logic [SIDE_W-1:0] board_height;
   } req_type;

   // Result word: cursor after the frame
   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_x;
      logic [CURSOR_W-1:0] cursor_y;
      logic [STEP_W-1:0]   step_count;
      logic [1:0]          active_direction;
   } rsp_type;

   // Per-direction slice status handed down the chain
   typedef struct packed {
      dir_type dir;    // active direction after this slice
      logic    step;   // this slice moved the cursor
   } slice_out_type;

endpackage

`default_nettype wire

// ----- hdl/cursor_autorepeat_controller.sv -----
// Top level of the cursor autorepeat controller; depends on cac_pkg, cac_dir_slice, cac_clamp.
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle while rsp_ready is high; under a result stall the input
//   register takes one more word, then req_ready drops until the result is taken.
// Reset (synchronous, active high): empties both registers, clears key history, countdowns,
//   cursor and active direction, and loads the delays 200 and 50.
`timescale 1ns / 1ps
`default_nettype none

module cursor_autorepeat_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input words
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire cac_pkg::req_type              req_data,
   // result words
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output cac_pkg::rsp_type                   rsp_data,
   // configuration writes
   input  wire logic                          csr_we,
   input  wire cac_pkg::csr_index_type        csr_index,
   input  wire logic [cac_pkg::TIME_W-1:0]    csr_wdata
);
   import cac_pkg::*;

   localparam logic [TIME_W-1:0] INIT_DELAY_RST = TIME_W'(200);
   localparam logic [TIME_W-1:0] REPEAT_RST     = TIME_W'(50);

   // Handshake registers
   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff, in_word_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_word_ff, rsp_word_in;

   // Configuration
   logic [TIME_W-1:0] init_delay_ff, init_delay_in;
   logic [TIME_W-1:0] repeat_ff, repeat_in;

   // Frame state
   logic [NUM_DIRS-1:0] press_seen_ff, press_seen_in;
   logic [TIME_W-1:0]   countdown_ff [NUM_DIRS];
   logic [TIME_W-1:0]   countdown_in [NUM_DIRS];
   dir_type             shift_dir_ff, shift_dir_in;
   logic [CURSOR_W-1:0] pos_x_ff, pos_x_in;
   logic [CURSOR_W-1:0] pos_y_ff, pos_y_in;

   // Datapath
   logic                out_free;
   logic                fire;
   logic [NUM_DIRS-1:0] held;
   logic [NUM_DIRS-1:0] fresh;
   logic [NUM_DIRS-1:0] steps;
   dir_type             dir_chain [NUM_DIRS+1];
   slice_out_type       slice_out [NUM_DIRS];
   logic signed [CALC_W-1:0] x_calc, y_calc;
   logic [CURSOR_W-1:0] x_clamped, y_clamped;
   logic [STEP_W-1:0]   step_count;

   // Flow control: the input register moves on when the output register frees up
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Key decode, order up, left, down, right
   assign held  = {in_word_ff.held_right, in_word_ff.held_down,
                   in_word_ff.held_left,  in_word_ff.held_up};
   assign fresh = held & ~press_seen_ff;

   // Direction slices chained in processing order
   assign dir_chain[0] = shift_dir_ff;

   for (genvar d = 0; d < NUM_DIRS; d++) begin : g_slice
      cac_dir_slice u_slice (
         .dir_idx         (dir_type'(2'(d))),
         .held            (held[d]),
         .fresh           (fresh[d]),
         .opp_held        (held[(d + 2) % NUM_DIRS]),
         .dir_in          (dir_chain[d]),
         .countdown       (countdown_ff[d]),
         .elapsed         (in_word_ff.elapsed_time),
         .initial_delay   (init_delay_ff),
         .repeat_interval (repeat_ff),
         .countdown_out   (countdown_in[d]),
         .slice_out       (slice_out[d])
      );
      assign dir_chain[d+1] = slice_out[d].dir;
      assign steps[d]       = slice_out[d].step;
   end

   // Net movement: left and up subtract, right and down add
   assign x_calc = signed'(CALC_W'(pos_x_ff) + CALC_W'(steps[MOVE_RIGHT])
                           - CALC_W'(steps[MOVE_LEFT]));
   assign y_calc = signed'(CALC_W'(pos_y_ff) + CALC_W'(steps[MOVE_DOWN])
                           - CALC_W'(steps[MOVE_UP]));
   assign step_count = STEP_W'(steps[0]) + STEP_W'(steps[1])
                     + STEP_W'(steps[2]) + STEP_W'(steps[3]);

   cac_clamp u_clamp_x (
      .coord   (x_calc),
      .side    (in_word_ff.board_width),
      .clamped (x_clamped)
   );

   cac_clamp u_clamp_y (
      .coord   (y_calc),
      .side    (in_word_ff.board_height),
      .clamped (y_clamped)
   );

   // Next-state logic
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      press_seen_in = press_seen_ff;
      shift_dir_in = shift_dir_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;

      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_data;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in                 = 1'b1;
         rsp_word_in.cursor_x         = x_clamped;
         rsp_word_in.cursor_y         = y_clamped;
         rsp_word_in.step_count       = step_count;
         rsp_word_in.active_direction = dir_chain[NUM_DIRS];
         press_seen_in = held;
         shift_dir_in  = dir_chain[NUM_DIRS];
         pos_x_in      = x_clamped;
         pos_y_in      = y_clamped;
      end
   end

   // Configuration writes
   always_comb begin
      init_delay_in = init_delay_ff;
      repeat_in     = repeat_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_DELAY:   init_delay_in = csr_wdata;
            CSR_REPEAT_INTERVAL: repeat_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         init_delay_ff <= INIT_DELAY_RST;
         repeat_ff     <= REPEAT_RST;
         press_seen_ff <= '0;
         shift_dir_ff  <= MOVE_UP;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         for (int i = 0; i < NUM_DIRS; i++) begin
            countdown_ff[i] <= '0;
         end
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         init_delay_ff <= init_delay_in;
         repeat_ff     <= repeat_in;
         press_seen_ff <= press_seen_in;
         shift_dir_ff  <= shift_dir_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         if (fire) begin
            for (int i = 0; i < NUM_DIRS; i++) begin
               countdown_ff[i] <= countdown_in[i];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

`default_nettype wire

// ----- hdl/cac_dir_slice.sv -----
// One direction slice: fresh press, hold takeover and repeat countdown.
// Depends on cac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cac_dir_slice (
   input  wire cac_pkg::dir_type             dir_idx,
   input  wire logic                         held,
   input  wire logic                         fresh,
   input  wire logic                         opp_held,
   input  wire cac_pkg::dir_type             dir_in,
   input  wire logic [cac_pkg::TIME_W-1:0]   countdown,
   input  wire logic [cac_pkg::TIME_W-1:0]   elapsed,
   input  wire logic [cac_pkg::TIME_W-1:0]   initial_delay,
   input  wire logic [cac_pkg::TIME_W-1:0]   repeat_interval,
   output logic      [cac_pkg::TIME_W-1:0]   countdown_out,
   output cac_pkg::slice_out_type            slice_out
);
   import cac_pkg::*;

   dir_type dir_taken;
   logic    expired;

   // A held key takes over unless its opposite is held too
   assign dir_taken = (held && !opp_held) ? dir_idx : dir_in;
   // Countdown minus elapsed reaches zero or below
   assign expired   = (countdown <= elapsed);

   always_comb begin
      countdown_out  = countdown;
      slice_out.dir  = dir_in;
      slice_out.step = 1'b0;
      if (fresh) begin
         countdown_out  = initial_delay;
         slice_out.dir  = dir_idx;
         slice_out.step = 1'b1;
      end else if (held) begin
         slice_out.dir = dir_taken;
         if (dir_taken == dir_idx) begin
            if (expired) begin
               countdown_out  = repeat_interval;
               slice_out.step = 1'b1;
            end else begin
               countdown_out = countdown - elapsed;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/cac_clamp.sv -----
// Clamps one signed cursor coordinate to a board side.
// Depends on cac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cac_clamp (
   input  wire logic signed [cac_pkg::CALC_W-1:0] coord,
   input  wire logic        [cac_pkg::SIDE_W-1:0] side,
   output logic             [cac_pkg::CURSOR_W-1:0] clamped
);
   import cac_pkg::*;

   logic        [SIDE_W-1:0] side_eff;
   logic signed [CALC_W-1:0] limit;
   logic signed [CALC_W-1:0] result;

   // Zero side counts as one, oversize as the maximum
   always_comb begin
      if (side == '0) begin
         side_eff = SIDE_W'(1);
      end else if (side > SIDE_W'(MAX_SIDE)) begin
         side_eff = SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = side;
      end
   end

   assign limit = signed'(CALC_W'(side_eff) - CALC_W'(1));

   always_comb begin
      if (coord < 0) begin
         result = '0;
      end else if (coord > limit) begin
         result = limit;
      end else begin
         result = coord;
      end
   end

   assign clamped = result[CURSOR_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/cac_checker.sv -----
// Port-level checks for the cursor autorepeat controller, bound to the top level.
// Depends on cac_pkg and cursor_autorepeat_controller.
`timescale 1ns / 1ps
`default_nettype none

module cac_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire cac_pkg::rsp_type       rsp_data
);
   import cac_pkg::*;

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // At most one step per direction in a frame
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.step_count <= STEP_W'(NUM_DIRS)))
      else $error("step_count above four");

   // A stalled result holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Two words of buffering: taking a word under a stall fills the block
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && req_valid && req_ready |=> rsp_ready || !req_ready)
      else $error("word accepted beyond buffer capacity");

endmodule

bind cursor_autorepeat_controller cac_checker u_cac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
